/* src/sphere_signed_distance_macros.svh */
// Assertion macros shared by the sphere signed distance RTL.
// Both macros expect a clock named clk and an active-low reset named rst_n.
`ifndef SPHERE_SIGNED_DISTANCE_MACROS_SVH
`define SPHERE_SIGNED_DISTANCE_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define SSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SSD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/ssd_pkg.sv */
// Package for the sphere signed distance block: widths, register indexes and
// the payload types handed from cell to cell. No dependencies.
`timescale 1ns / 1ps

package ssd_pkg;

    // Number of active axes (2 or 3); the z lanes are forced to zero below 3.
    localparam int DIMS = 3;
    localparam int NAX = 3;

    localparam int SQ_STEPS = 34;   // root bits of a 66-bit sum of squares
    localparam int DIV_STEPS = 32;  // quotient bits of each divider lane
    localparam int NLANE = 2 * NAX; // normal lanes first, then surface lanes

    localparam int ADDR_W = 4;

    typedef logic [1:0] ssd_reg_idx_t;
    localparam ssd_reg_idx_t REG_RADIUS   = 2'd0;
    localparam ssd_reg_idx_t REG_CENTER_X = 2'd1;
    localparam ssd_reg_idx_t REG_CENTER_Y = 2'd2;
    localparam ssd_reg_idx_t REG_CENTER_Z = 2'd3;

    // Payload of one square root cell.
    typedef struct packed {
        logic [67:0]          rad;    // radicand, next pair of bits on top
        logic [36:0]          rem;
        logic [33:0]          root;
        logic [NAX-1:0][31:0] mag;
        logic [NAX-1:0][62:0] prod;   // |d| * radius
        logic [NAX-1:0]       neg;
        logic                 center;
    } ssd_sq_t;

    // Payload of one divider cell.
    typedef struct packed {
        logic [33:0]            root;
        logic [NLANE-1:0][31:0] num;  // low numerator bits, next bit on top
        logic [NLANE-1:0][33:0] rem;
        logic [NLANE-1:0][31:0] quo;
        logic [NAX-1:0]         neg;
        logic                   center;
    } ssd_dv_t;

endpackage

/* src/ssd_sqrt_cell.sv */
// One cell of the square root chain: resolves one root bit per transaction.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_sqrt_cell
    import ssd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  ssd_sq_t in_data,
    output logic    out_valid,
    output ssd_sq_t out_data
);

    logic    valid_reg;
    ssd_sq_t data_reg;
    ssd_sq_t data_next;
    logic [36:0] rem_sh;
    logic [36:0] trial;
    logic        ge;

    always_comb
    begin
        rem_sh = {in_data.rem[34:0], in_data.rad[67:66]};
        trial = {1'b0, in_data.root, 2'b01};
        ge = (rem_sh >= trial);
        data_next = in_data;
        data_next.rad = {in_data.rad[65:0], 2'b00};
        data_next.rem = ge ? (rem_sh - trial) : rem_sh;
        data_next.root = {in_data.root[32:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

/* src/ssd_div_cell.sv */
// One cell of the divider chain: one quotient bit for each of the six lanes.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_div_cell
    import ssd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  ssd_dv_t in_data,
    output logic    out_valid,
    output ssd_dv_t out_data
);

    logic    valid_reg;
    ssd_dv_t data_reg;
    ssd_dv_t data_next;
    logic [NLANE-1:0][34:0] rem_sh;
    logic [NLANE-1:0][34:0] diff;
    logic [NLANE-1:0]       ge;

    always_comb
    begin
        data_next = in_data;
        for (int k = 0; k < NLANE; k++)
        begin
            rem_sh[k] = {in_data.rem[k], in_data.num[k][31]};
            diff[k] = rem_sh[k] - {1'b0, in_data.root};
            ge[k] = (rem_sh[k] >= {1'b0, in_data.root});
            data_next.rem[k] = ge[k] ? diff[k][33:0] : rem_sh[k][33:0];
            data_next.num[k] = {in_data.num[k][30:0], 1'b0};
            data_next.quo[k] = {in_data.quo[k][30:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

/* src/sphere_signed_distance.sv */
// Top level of the sphere signed distance block: register port, front stages,
// square root and divider cell chains, output register.
// Depends on ssd_pkg, ssd_sqrt_cell, ssd_div_cell and the assertion macros.
//
// Usage: a query point enters on the s_axis stream as one transaction and
// leaves on the m_axis stream as one transaction carrying the signed distance,
// the unit outward normal, the nearest surface point and two status flags.
// The sphere is set through the APB-style port: radius at byte 0, center x,
// y and z at 4, 8 and 12. Write it only while no point is in flight.
// An input transaction passes to its result through three front
// stages (difference, multipliers, sum of squares), 34 square root cells, one
// numerator stage, 32 divider cells and the output register. The chain is a
// single pipeline, so one point is accepted every cycle unless the receiver
// stalls, and the rate is set by one root bit or one quotient bit per cell per cycle.
// When the receiver stalls with a result waiting, the whole chain holds and
// s_axis_tready drops in the same cycle; it rises again as soon as the waiting
// result is taken. Reset empties the chain and restores radius 1.0 with the
// center at the origin.
`timescale 1ns / 1ps
`include "sphere_signed_distance_macros.svh"

module sphere_signed_distance
    import ssd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input stream.
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [95:0]        s_axis_tdata,  // pos_x, pos_y, pos_z
    // Output stream.
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // signed_distance, normal_x, normal_y, normal_z, exit_x, exit_y, exit_z, 2 zero bits
    output logic [183:0]       m_axis_tdata,
    output logic [1:0]         m_axis_tuser   // at_center, saturated
);

    // Configuration registers.
    logic [30:0]          radius_reg;
    logic [NAX-1:0][31:0] center_reg;
    ssd_reg_idx_t         cfg_idx;

    assign cfg_idx = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 31'd65536;
            center_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (cfg_idx)
                REG_RADIUS:   radius_reg <= pwdata[30:0];
                REG_CENTER_X: center_reg[0] <= pwdata;
                REG_CENTER_Y: center_reg[1] <= pwdata;
                REG_CENTER_Z: center_reg[2] <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_RADIUS:   prdata = {1'b0, radius_reg};
            REG_CENTER_X: prdata = center_reg[0];
            REG_CENTER_Y: prdata = center_reg[1];
            REG_CENTER_Z: prdata = center_reg[2];
            default:      prdata = '0;
        endcase
    end

    // The whole chain advances together unless a finished result is stuck.
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: center-relative difference, split into magnitude and sign.
    logic                 s1_valid_reg;
    logic [NAX-1:0][31:0] s1_mag_reg;
    logic [NAX-1:0]       s1_neg_reg;
    logic [NAX-1:0][31:0] s1_mag_next;
    logic [NAX-1:0]       s1_neg_next;
    logic [NAX-1:0][32:0] diff;

    always_comb
    begin
        for (int k = 0; k < NAX; k++)
        begin
            diff[k] = {s_axis_tdata[32*k+31], s_axis_tdata[32*k +: 32]}
                    - {center_reg[k][31], center_reg[k]};
            if (k < DIMS)
            begin
                s1_neg_next[k] = diff[k][32];
                s1_mag_next[k] = diff[k][32] ? 32'(-diff[k]) : diff[k][31:0];
            end
            else
            begin
                s1_neg_next[k] = 1'b0;
                s1_mag_next[k] = '0;
            end
        end
    end

    // Stage 2: squares and the products with the radius.
    logic                 s2_valid_reg;
    logic [NAX-1:0][31:0] s2_mag_reg;
    logic [NAX-1:0]       s2_neg_reg;
    logic [NAX-1:0][63:0] s2_sq_reg;
    logic [NAX-1:0][62:0] s2_prod_reg;
    logic [NAX-1:0][63:0] s2_sq_next;
    logic [NAX-1:0][62:0] s2_prod_next;

    always_comb
    begin
        for (int k = 0; k < NAX; k++)
        begin
            s2_sq_next[k] = s1_mag_reg[k] * s1_mag_reg[k];
            s2_prod_next[k] = s1_mag_reg[k] * radius_reg;
        end
    end

    // Stage 3: sum of squares seeds the root chain.
    logic    s3_valid_reg;
    ssd_sq_t s3_data_reg;
    ssd_sq_t s3_data_next;
    logic [65:0] sum_sq;

    always_comb
    begin
        sum_sq = 66'(s2_sq_reg[0]) + 66'(s2_sq_reg[1]) + 66'(s2_sq_reg[2]);
        s3_data_next.rad = {2'b00, sum_sq};
        s3_data_next.rem = '0;
        s3_data_next.root = '0;
        s3_data_next.mag = s2_mag_reg;
        s3_data_next.prod = s2_prod_reg;
        s3_data_next.neg = s2_neg_reg;
        s3_data_next.center = (sum_sq == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_axis_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg <= s1_mag_next;
            s1_neg_reg <= s1_neg_next;
            s2_mag_reg <= s1_mag_reg;
            s2_neg_reg <= s1_neg_reg;
            s2_sq_reg <= s2_sq_next;
            s2_prod_reg <= s2_prod_next;
            s3_data_reg <= s3_data_next;
        end
    end

    // Square root chain, most significant root bit first.
    logic    sq_valid [0:SQ_STEPS];
    ssd_sq_t sq_data  [0:SQ_STEPS];

    assign sq_valid[0] = s3_valid_reg;
    assign sq_data[0] = s3_data_reg;

    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        ssd_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_valid[i]),
            .in_data   (sq_data[i]),
            .out_valid (sq_valid[i+1]),
            .out_data  (sq_data[i+1])
        );
    end

    // Numerator stage: rounding term r/2 is added before the divide.
    logic    nm_valid_reg;
    ssd_dv_t nm_data_reg;
    ssd_dv_t nm_data_next;
    logic [NLANE-1:0][63:0] numer;
    logic [33:0] root_s;

    always_comb
    begin
        root_s = sq_data[SQ_STEPS].root;
        for (int k = 0; k < NAX; k++)
        begin
            numer[k] = {16'b0, sq_data[SQ_STEPS].mag[k], 16'b0} + 64'(root_s[33:1]);
            numer[NAX+k] = {1'b0, sq_data[SQ_STEPS].prod[k]} + 64'(root_s[33:1]);
        end
        nm_data_next.root = root_s;
        for (int k = 0; k < NLANE; k++)
        begin
            nm_data_next.num[k] = numer[k][31:0];
            nm_data_next.rem[k] = {2'b00, numer[k][63:32]};
            nm_data_next.quo[k] = '0;
        end
        nm_data_next.neg = sq_data[SQ_STEPS].neg;
        nm_data_next.center = sq_data[SQ_STEPS].center;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            nm_valid_reg <= sq_valid[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_data_reg <= nm_data_next;
        end
    end

    // Divider chain, six lanes side by side.
    logic    dv_valid [0:DIV_STEPS];
    ssd_dv_t dv_data  [0:DIV_STEPS];

    assign dv_valid[0] = nm_valid_reg;
    assign dv_data[0] = nm_data_reg;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        ssd_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_valid[i]),
            .in_data   (dv_data[i]),
            .out_valid (dv_valid[i+1]),
            .out_data  (dv_data[i+1])
        );
    end

    // Output stage: signs, saturation and the special cases.
    logic                 out_valid_reg;
    logic [31:0]          dist_reg;
    logic [NAX-1:0][17:0] normal_reg;
    logic [NAX-1:0][31:0] exit_reg;
    logic                 center_out_reg;
    logic                 sat_reg;
    logic [31:0]          dist_next;
    logic [NAX-1:0][17:0] normal_next;
    logic [NAX-1:0][31:0] exit_next;
    logic                 sat_next;
    logic signed [35:0]   dist_w;
    logic signed [34:0]   exit_w;
    logic signed [34:0]   offs;
    ssd_dv_t              fin;

    always_comb
    begin
        fin = dv_data[DIV_STEPS];
        sat_next = 1'b0;
        dist_w = $signed({2'b00, fin.root}) - $signed({5'b0, radius_reg});
        if (dist_w > 36'sd2147483647)
        begin
            dist_next = 32'h7fff_ffff;
            sat_next = 1'b1;
        end
        else if (dist_w < -36'sd2147483648)
        begin
            dist_next = 32'h8000_0000;
            sat_next = 1'b1;
        end
        else
        begin
            dist_next = dist_w[31:0];
        end
        for (int k = 0; k < NAX; k++)
        begin
            normal_next[k] = '0;
            exit_next[k] = '0;
            offs = fin.neg[k] ? -$signed({3'b0, fin.quo[NAX+k]})
                              : $signed({3'b0, fin.quo[NAX+k]});
            exit_w = $signed({{3{center_reg[k][31]}}, center_reg[k]}) + offs;
            if (k < DIMS && !fin.center)
            begin
                normal_next[k] = fin.neg[k] ? 18'(-fin.quo[k][17:0]) : fin.quo[k][17:0];
                if (exit_w > 35'sd2147483647)
                begin
                    exit_next[k] = 32'h7fff_ffff;
                    sat_next = 1'b1;
                end
                else if (exit_w < -35'sd2147483648)
                begin
                    exit_next[k] = 32'h8000_0000;
                    sat_next = 1'b1;
                end
                else
                begin
                    exit_next[k] = exit_w[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= dist_next;
            normal_reg <= normal_next;
            exit_reg <= exit_next;
            center_out_reg <= fin.center;
            sat_reg <= sat_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {2'b00, exit_reg[2], exit_reg[1], exit_reg[0],
                           normal_reg[2], normal_reg[1], normal_reg[0], dist_reg};
    assign m_axis_tuser = {sat_reg, center_out_reg};

    // A point at the center has no direction: normals and surface point are zero.
    `SSD_ASSERT_IMPL(a_center_zero, out_valid_reg && center_out_reg,
        normal_reg == '0 && exit_reg == '0, "center result with nonzero normal or exit")
    // At the center the distance is exactly minus the radius.
    `SSD_ASSERT_IMPL(a_center_dist, out_valid_reg && center_out_reg,
        dist_reg == 32'(-{1'b0, radius_reg}), "center result with wrong distance")
    // Normal components never exceed unit length.
    `SSD_ASSERT_IMPL(a_normal_range, out_valid_reg,
        ($signed(normal_reg[0]) <= 18'sd65536 && $signed(normal_reg[0]) >= -18'sd65536) &&
        ($signed(normal_reg[1]) <= 18'sd65536 && $signed(normal_reg[1]) >= -18'sd65536) &&
        ($signed(normal_reg[2]) <= 18'sd65536 && $signed(normal_reg[2]) >= -18'sd65536),
        "normal component out of range")

endmodule
